FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: rtl/ntcd_pkg.sv
// Package: constants and types of the corner detector.
package ntcd_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MIN_SIDE     = 3;
    localparam int CORNER_COUNT = 3;

    localparam int PIXEL_W  = 8;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 12;
    localparam int THR_W    = 8;
    localparam int WID_W    = 12;
    localparam int HGT_W    = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;

    localparam int LINE_AW  = $clog2(MAX_WIDTH);
    localparam int LINE_DW  = 2 * PIXEL_W;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             is_corner;
        logic             frame_last;
    } result_t;

    typedef struct packed {
        logic [LINE_AW-1:0] addr;
        logic [PIXEL_W-1:0] px;
        logic               emit;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               last;
    } stage_t;

endpackage

FILE: rtl/ntcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ntcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/neighbour_threshold_corner_detect.sv
// Top level: streaming 3x3 neighbour-threshold corner detector.
//
// Takes one 8-bit grayscale pixel per word in raster order and returns one
// result word per interior pixel (column, row, corner flag, end-of-frame
// flag); border pixels produce nothing. Sustained rate is one pixel per
// clock while the sink keeps up. A result is presented on the output from
// the clock edge after the one that accepts the pixel completing its
// window (the bottom-right neighbour). The two previous rows sit in one
// 2048 x 16 line RAM (both line banks side by side), which is read in the
// accept cycle and written back in the following cycle with the rows moved
// down; consecutive pixels always hit different columns, so no forwarding
// is needed. A three-word output queue decouples the sink: in_ready drops
// once the queued words plus the word in flight take all three places.
// Width and height are clamped to [3, 2048] and [3, 4096]. Configuration
// writes are taken at any time but are only meant while the block is idle;
// they act on the next pixel. The line RAM is not cleared after reset; its
// contents are never observed before being written in a well-formed stream.
module neighbour_threshold_corner_detect (
    input  logic                               clk,
    input  logic                               rst_n,
    // pixel input
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ntcd_pkg::PIXEL_W-1:0]       pixel,
    // result output
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ntcd_pkg::COL_W-1:0]         col,
    output logic [ntcd_pkg::ROW_W-1:0]         row,
    output logic                               is_corner,
    output logic                               frame_last,
    // configuration
    input  logic                               cfg_we,
    input  logic [ntcd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [ntcd_pkg::CFG_W-1:0]         cfg_wdata
);
    import ntcd_pkg::*;

    // configuration registers
    logic [THR_W-1:0] thr_reg;
    logic [WID_W-1:0] wid_reg;
    logic [HGT_W-1:0] hgt_reg;

    // raster position of the next pixel
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // stage 1: pixel whose line data is coming out of the RAM
    logic   s1_valid_reg;
    stage_t s1_reg, s1_next;

    // 3x3 window, [row][col], col 2 newest
    logic [PIXEL_W-1:0] win_reg  [3][3];
    logic [PIXEL_W-1:0] win_next [3][3];

    // output queue
    result_t             fifo_reg [FIFO_DEPTH];
    logic [FIFO_PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]  cnt_reg, cnt_next;

    logic [WID_W-1:0]   w_eff;
    logic [HGT_W-1:0]   h_eff;
    logic               accept, push, pop;
    logic [COL_W-1:0]   c_cur;
    logic [ROW_W-1:0]   r_cur;
    logic [LINE_DW-1:0] line_rd;
    result_t            res;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(30);
            wid_reg <= WID_W'(640);
            hgt_reg <= HGT_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_THRESHOLD: thr_reg <= cfg_wdata[THR_W-1:0];
                CFG_WIDTH:     wid_reg <= cfg_wdata[WID_W-1:0];
                CFG_HEIGHT:    hgt_reg <= cfg_wdata[HGT_W-1:0];
                default:       ;
            endcase
        end
    end

    // clamp to the supported frame size
    always_comb
    begin
        if (wid_reg < WID_W'(MIN_SIDE))
            w_eff = WID_W'(MIN_SIDE);
        else if (wid_reg > WID_W'(MAX_WIDTH))
            w_eff = WID_W'(MAX_WIDTH);
        else
            w_eff = wid_reg;

        if (hgt_reg < HGT_W'(MIN_SIDE))
            h_eff = HGT_W'(MIN_SIDE);
        else if (hgt_reg > HGT_W'(MAX_HEIGHT))
            h_eff = HGT_W'(MAX_HEIGHT);
        else
            h_eff = hgt_reg;
    end

    // ---------------- handshake ----------------
    // room for the word in flight plus a new one
    assign in_ready = ({1'b0, cnt_reg} + {{FIFO_CW{1'b0}}, s1_valid_reg})
                      < (FIFO_CW + 1)'(FIFO_DEPTH);
    assign accept   = in_valid && in_ready;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign push      = s1_valid_reg && s1_reg.emit;

    // ---------------- position counters ----------------
    always_comb
    begin
        logic [ROW_W:0]   r_wrap;
        logic [WID_W-1:0] c_inc;
        logic [ROW_W:0]   r_inc;

        // a position beyond the frame (size shrunk while idle) wraps first
        if ({1'b0, col_reg} >= w_eff)
        begin
            c_cur  = '0;
            r_wrap = {1'b0, row_reg} + (ROW_W + 1)'(1);
        end
        else
        begin
            c_cur  = col_reg;
            r_wrap = {1'b0, row_reg};
        end
        r_cur = (r_wrap >= h_eff) ? '0 : r_wrap[ROW_W-1:0];

        c_inc = {1'b0, c_cur} + WID_W'(1);
        r_inc = {1'b0, r_cur} + (ROW_W + 1)'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (c_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = c_inc[COL_W-1:0];
                row_next = r_cur;
            end
        end

        s1_next.addr = c_cur[LINE_AW-1:0];
        s1_next.px   = pixel;
        s1_next.emit = (c_cur >= COL_W'(2)) && (r_cur >= ROW_W'(2));
        s1_next.col  = c_cur - COL_W'(1);
        s1_next.row  = r_cur - ROW_W'(1);
        s1_next.last = ({1'b0, c_cur} == w_eff - WID_W'(1))
                    && ({1'b0, r_cur} == h_eff - HGT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    // ---------------- line RAM ----------------
    // [15:8] row r-2, [7:0] row r-1; write back moves r-1 down
    ntcd_ram #(
        .WIDTH (LINE_DW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_reg.addr),
        .wdata ({line_rd[PIXEL_W-1:0], s1_reg.px}),
        .re    (accept),
        .raddr (s1_next.addr),
        .rdata (line_rd)
    );

    // ---------------- window and evaluation ----------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = line_rd[LINE_DW-1:PIXEL_W];
        win_next[1][2] = line_rd[PIXEL_W-1:0];
        win_next[2][2] = s1_reg.px;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (s1_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    // compare the eight neighbours of the new window's centre
    always_comb
    begin
        logic [PIXEL_W:0] hi;
        logic [PIXEL_W:0] n_ext;
        logic [3:0]       n_bright;
        logic [3:0]       n_dark;

        hi       = {1'b0, win_next[1][1]} + {1'b0, thr_reg};
        n_bright = '0;
        n_dark   = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!(i == 1 && j == 1))
                begin
                    n_ext = {1'b0, win_next[i][j]};
                    if (n_ext > hi)
                        n_bright = n_bright + 4'd1;
                    if (n_ext + {1'b0, thr_reg} < {1'b0, win_next[1][1]})
                        n_dark = n_dark + 4'd1;
                end
            end
        end

        res.col        = s1_reg.col;
        res.row        = s1_reg.row;
        res.is_corner  = (n_bright >= 4'(CORNER_COUNT)) || (n_dark >= 4'(CORNER_COUNT));
        res.frame_last = s1_reg.last;
    end

    // ---------------- output queue ----------------
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + FIFO_CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - FIFO_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PW'(FIFO_DEPTH - 1))
                              ? '0 : wr_ptr_reg + FIFO_PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PW'(FIFO_DEPTH - 1))
                              ? '0 : rd_ptr_reg + FIFO_PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

    assign col        = fifo_reg[rd_ptr_reg].col;
    assign row        = fifo_reg[rd_ptr_reg].row;
    assign is_corner  = fifo_reg[rd_ptr_reg].is_corner;
    assign frame_last = fifo_reg[rd_ptr_reg].frame_last;
endmodule

FILE: rtl/ntcd_checker.sv
// Checker on the corner detector's ports, bound to the top level.
`include "assert_macros.svh"

module ntcd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [ntcd_pkg::COL_W-1:0]     col,
    input logic [ntcd_pkg::ROW_W-1:0]     row,
    input logic                           is_corner,
    input logic                           frame_last
);
    import ntcd_pkg::*;

    // a stalled result word holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(col) && $stable(row) && $stable(is_corner) && $stable(frame_last))

    // back-pressure only while results are queued
    `ASSERT_NOW(a_ready_only_when_full, clk, rst_n, !in_ready, out_valid)

    // an empty output queue fills only from an accepted pixel that passed through stage 1
    `ASSERT_NOW(a_result_from_pixel, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

    // results are interior pixels only
    `ASSERT_NOW(a_interior_only, clk, rst_n, out_valid, col != '0 && row != '0 && col < COL_W'(MAX_WIDTH - 1))
endmodule

bind neighbour_threshold_corner_detect ntcd_checker u_ntcd_checker (.*);
